### rtl/cttr_pkg.sv
// ----------------------------------------------------------------------------
// Colour temperature to RGB: shared package
// Widths, fixed-point constants, stage latencies and elaboration-time helper
// functions for the log2 and exp2 pipelines.
// ----------------------------------------------------------------------------
package cttr_pkg;

	// Default output level width.
	localparam int OUT_BITS_DEF = 8;

	// Input width and internal word widths.
	localparam int KELVIN_W = 16;
	localparam int LG_W     = 26;   // signed log2 value, Q20
	localparam int V_W      = 32;   // signed channel value, Q16
	localparam int A_W      = 24;   // linear slope width, Q16
	localparam int B_W      = 25;   // linear offset width, Q16
	localparam int C_W      = 25;   // power scale width, Q16
	localparam int P_W      = 18;   // power exponent magnitude width, Q20

	// Stage latencies of the datapath units.
	localparam int LAT_LOG  = 22;
	localparam int LAT_LIN  = 4;
	localparam int LAT_POW  = 24;
	localparam int LAT_CORE = LAT_LOG + LAT_POW;

	// Fixed-point coefficients.
	localparam logic [29:0]    LN2_Q30   = 30'd744261118;
	localparam logic [C_W-1:0] RED_C_Q16 = 25'd21607136;
	localparam logic [P_W-1:0] RED_P_Q20 = 18'd139675;
	localparam logic [C_W-1:0] GRN_C_Q16 = 25'd18882375;
	localparam logic [P_W-1:0] GRN_P_Q20 = 18'd79183;
	localparam logic [A_W-1:0] GRN_A_Q16 = 24'd6518919;
	localparam logic [B_W-1:0] GRN_B_Q16 = 25'd10559132;
	localparam logic [A_W-1:0] BLU_A_Q16 = 24'd9077898;
	localparam logic [B_W-1:0] BLU_B_Q16 = 25'd19991416;
	localparam logic signed [V_W-1:0] TOP_Q16 = 32'sd16711680;

	// Temperature thresholds and offsets in kelvin.
	localparam logic [KELVIN_W-1:0] K_HI      = 16'd6600;
	localparam logic [KELVIN_W-1:0] K_BLO     = 16'd1900;
	localparam logic [KELVIN_W-1:0] K_RED_OFF = 16'd6000;
	localparam logic [KELVIN_W-1:0] K_BLU_OFF = 16'd1000;

	// Range flags that travel alongside each word.
	typedef struct packed {
		logic hi;      // above the red/green knee
		logic kzero;   // zero kelvin
		logic bsat;    // blue at full
		logic bzero;   // blue off
	} cttr_flags_t;

	// Floor square root, used only to build constants.
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x   = x_in;
		res = '0;
		b   = 64'(1) << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x   = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Q30 root 2^(2^-i), built by repeated square roots.
	function automatic logic [63:0] root_q30(input int i);
		logic [63:0] r;
		r = isqrt64(64'(1) << 61);
		for (int j = 1; j < i; j++)
			r = isqrt64(r << 30);
		return r;
	endfunction

	// Q20 log2 by repeated squaring, the same steps as the hardware pipeline.
	function automatic logic signed [LG_W-1:0] log2_q20_const(input int unsigned n);
		int unsigned e;
		logic [63:0] m;
		logic [19:0] fr;
		e = 0;
		while (e < 31 && (n >> (e + 1)) != 0)
			e++;
		m  = 64'(n) << (30 - e);
		fr = '0;
		for (int i = 1; i <= 20; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'(1) << 31)) begin
				fr[20-i] = 1'b1;
				m = m >> 1;
			end
		end
		return LG_W'(e << 20) + LG_W'(fr);
	endfunction

	localparam logic signed [LG_W-1:0] L100 = log2_q20_const(100);

endpackage

### rtl/cttr_log2.sv
// ----------------------------------------------------------------------------
// Colour temperature to RGB: log2 pipeline
// Normalises the argument, then one squaring stage per fraction bit gives
// log2(n) in Q20; the last stage subtracts log2(100).
// ----------------------------------------------------------------------------
module cttr_log2 (
	input  logic                              clk,
	input  logic [cttr_pkg::KELVIN_W-1:0]     n,
	output logic signed [cttr_pkg::LG_W-1:0]  lg
);
	import cttr_pkg::*;

	logic [3:0]  e_c;
	logic [30:0] m_c;
	logic [30:0] m_s  [0:20];
	logic [19:0] fr_s [0:20];
	logic [3:0]  e_s  [0:20];

	// Leading one position and mantissa in Q30.
	always_comb begin
		e_c = '0;
		for (int b = 1; b < KELVIN_W; b++)
			if (n[b])
				e_c = 4'(b);
		m_c = {15'b0, n} << (5'd30 - 5'(e_c));
	end

	always_ff @(posedge clk) begin
		m_s[0]  <= m_c;
		fr_s[0] <= '0;
		e_s[0]  <= e_c;
	end

	// One squaring per fraction bit; a square of two or more yields a one.
	for (genvar gi = 1; gi <= 20; gi++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] mn;
		assign sq = m_s[gi-1] * m_s[gi-1];
		assign mn = sq[61:30];
		always_ff @(posedge clk) begin
			e_s[gi] <= e_s[gi-1];
			if (mn[31]) begin
				m_s[gi]  <= mn[31:1];
				fr_s[gi] <= fr_s[gi-1] | (20'(1) << (20 - gi));
			end else begin
				m_s[gi]  <= mn[30:0];
				fr_s[gi] <= fr_s[gi-1];
			end
		end
	end

	// Result relative to a temperature of one hundred kelvin.
	always_ff @(posedge clk) begin
		lg <= $signed(LG_W'({e_s[20], fr_s[20]})) - L100;
	end

endmodule

### rtl/cttr_lin.sv
// ----------------------------------------------------------------------------
// Colour temperature to RGB: linear log term
// Converts log2 to ln and forms a*ln - b in Q16, padded to the length of
// the power pipeline.
// ----------------------------------------------------------------------------
module cttr_lin (
	input  logic                              clk,
	input  logic signed [cttr_pkg::LG_W-1:0]  lg,
	input  logic [cttr_pkg::A_W-1:0]          a_coef,
	input  logic [cttr_pkg::B_W-1:0]          b_coef,
	output logic signed [cttr_pkg::V_W-1:0]   v
);
	import cttr_pkg::*;

	localparam int PAD = LAT_POW - LAT_LIN;

	logic [LG_W-2:0] mag_c;
	logic            neg_s1, neg_s2, neg_s3;
	logic [54:0]     prod_s1;
	logic [24:0]     ln_s2;
	logic [48:0]     prod_s3;
	logic [28:0]     mag4_c;
	logic signed [V_W-1:0] v_s4;
	logic signed [V_W-1:0] dly_q [0:PAD-1];

	assign mag_c  = lg[LG_W-1] ? (LG_W-1)'(-lg) : lg[LG_W-2:0];
	assign mag4_c = 29'((prod_s3 + (49'(1) << 19)) >> 20);

	// Magnitude times ln 2, then rounding, then slope, then offset.
	always_ff @(posedge clk) begin
		neg_s1  <= lg[LG_W-1];
		prod_s1 <= mag_c * LN2_Q30;
		neg_s2  <= neg_s1;
		ln_s2   <= 25'((prod_s1 + (55'(1) << 29)) >> 30);
		neg_s3  <= neg_s2;
		prod_s3 <= ln_s2 * a_coef;
		v_s4    <= (neg_s3 ? -$signed(V_W'(mag4_c)) : $signed(V_W'(mag4_c)))
			- $signed(V_W'(b_coef));
	end

	// Delay line to line up with the power path.
	always_ff @(posedge clk) begin
		dly_q[0] <= v_s4;
		for (int i = 1; i < PAD; i++)
			dly_q[i] <= dly_q[i-1];
	end

	assign v = dly_q[PAD-1];

endmodule

### rtl/cttr_pow.sv
// ----------------------------------------------------------------------------
// Colour temperature to RGB: power pipeline
// Computes c * 2^(-p * lg) in Q16 through a split into whole and fractional
// exponent, one stage per fraction bit of the exp2 product.
// ----------------------------------------------------------------------------
module cttr_pow (
	input  logic                              clk,
	input  logic signed [cttr_pkg::LG_W-1:0]  lg,
	input  logic [cttr_pkg::C_W-1:0]          c_coef,
	input  logic [cttr_pkg::P_W-1:0]          p_coef,
	output logic signed [cttr_pkg::V_W-1:0]   v
);
	import cttr_pkg::*;

	logic [42:0] prod_s1;
	logic [22:0] m_c;
	logic [5:0]  n_c;
	logic [31:0] r_s [0:20];
	logic [19:0] f_s [0:20];
	logic [5:0]  n_s [0:20];
	logic [56:0] prod_s3;
	logic [5:0]  n_s3;
	logic [5:0]  sh_c;
	logic [63:0] v_c;

	// Exponent magnitude, then whole part rounded up and fraction below it.
	assign m_c = 23'((prod_s1 + (43'(1) << 19)) >> 20);
	assign n_c = 6'((24'(m_c) + 24'hFFFFF) >> 20);

	always_ff @(posedge clk) begin
		prod_s1 <= p_coef * lg[LG_W-2:0];
		r_s[0]  <= 32'(1) << 30;
		f_s[0]  <= 20'd0 - m_c[19:0];
		n_s[0]  <= n_c;
	end

	// One conditional multiplication by a root of two per fraction bit.
	for (genvar gi = 1; gi <= 20; gi++) begin : g_exp
		localparam logic [31:0] ROOT = 32'(root_q30(gi));
		logic [63:0] pr;
		assign pr = r_s[gi-1] * ROOT;
		always_ff @(posedge clk) begin
			f_s[gi] <= f_s[gi-1];
			n_s[gi] <= n_s[gi-1];
			if (f_s[gi-1][20-gi])
				r_s[gi] <= 32'((pr + (64'(1) << 29)) >> 30);
			else
				r_s[gi] <= r_s[gi-1];
		end
	end

	// Scale, then rounded shift by the whole exponent.
	assign sh_c = 6'd30 + n_s3;
	assign v_c  = (64'(prod_s3) + (64'(1) << (sh_c - 6'd1))) >> sh_c;

	always_ff @(posedge clk) begin
		prod_s3 <= c_coef * r_s[20];
		n_s3    <= n_s[20];
		v       <= $signed(V_W'(v_c));
	end

endmodule

### rtl/cttr_level.sv
// ----------------------------------------------------------------------------
// Colour temperature to RGB: output level
// Clamps a Q16 value to 0..255 and rescales it to the output width with
// rounding, dividing by 255 through a reciprocal and one correction.
// ----------------------------------------------------------------------------
module cttr_level #(
	parameter int OUT_BITS = cttr_pkg::OUT_BITS_DEF
) (
	input  logic                             clk,
	input  logic signed [cttr_pkg::V_W-1:0]  v,
	output logic [OUT_BITS-1:0]              lvl
);
	import cttr_pkg::*;

	localparam int XW = 24 + OUT_BITS;
	localparam logic [OUT_BITS-1:0] FULL = '1;

	logic          zero_s1, top_s1, zero_s2, top_s2;
	logic [XW-1:0] x_s1;
	logic [23:0]   y_c, y_s2;
	logic [40:0]   qp_c;
	logic [16:0]   q0_s2;
	logic [24:0]   r_c;
	logic [16:0]   q_c;

	// Scaled value with half a step added.
	always_ff @(posedge clk) begin
		zero_s1 <= v[V_W-1] || (v == '0);
		top_s1  <= v >= TOP_Q16;
		x_s1    <= XW'(v[23:0]) * XW'(FULL) + (XW'(255) << 15);
	end

	// First quotient estimate, at most one short.
	assign y_c  = 24'(x_s1 >> 16);
	assign qp_c = y_c * 17'd65793;

	always_ff @(posedge clk) begin
		zero_s2 <= zero_s1;
		top_s2  <= top_s1;
		y_s2    <= y_c;
		q0_s2   <= 17'(qp_c >> 24);
	end

	// Correction step and clamping.
	assign r_c = {1'b0, y_s2} - 25'(q0_s2 * 9'd255);
	assign q_c = q0_s2 + 17'(r_c >= 25'd255);

	always_ff @(posedge clk) begin
		if (zero_s2)
			lvl <= '0;
		else if (top_s2)
			lvl <= FULL;
		else
			lvl <= OUT_BITS'(q_c);
	end

endmodule

### rtl/color_temperature_to_rgb_unit.sv
// ----------------------------------------------------------------------------
// Colour temperature to RGB unit
// Throughput: one word per cycle; busy is never raised as the pipeline
// has no stall and the receiver cannot hold results off.
// Reset clears the valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb_unit #(
	parameter int OUT_BITS = cttr_pkg::OUT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [cttr_pkg::KELVIN_W-1:0]  kelvin,
	output logic                           done,
	output logic [OUT_BITS-1:0]            red,
	output logic [OUT_BITS-1:0]            green,
	output logic [OUT_BITS-1:0]            blue
);
	import cttr_pkg::*;

	localparam int LAT_LVL = 3;

	cttr_flags_t           flags_c, flags_s1, flags_s2;
	logic [KELVIN_W-1:0]   arga_c, argb_c, arga_s1, argb_s1;
	logic                  valid_s1, valid_s2;
	logic                  core_vld_q [0:LAT_CORE-1];
	cttr_flags_t           core_flg_q [0:LAT_CORE-1];
	logic                  lvl_vld_q  [0:LAT_LVL-1];
	logic signed [LG_W-1:0] lga, lgb;
	logic signed [V_W-1:0] grn_lin, blu_lin, red_pow, grn_pow;
	logic signed [V_W-1:0] red_v_s2, grn_v_s2, blu_v_s2;

	assign busy = 1'b0;

	// Range decisions and log arguments.
	always_comb begin
		flags_c.hi    = kelvin > K_HI;
		flags_c.kzero = kelvin == '0;
		flags_c.bsat  = kelvin >= K_HI;
		flags_c.bzero = kelvin <= K_BLO;
		if (flags_c.hi)
			arga_c = kelvin - K_RED_OFF;
		else if (flags_c.kzero)
			arga_c = KELVIN_W'(1);
		else
			arga_c = kelvin;
		if (flags_c.bsat || flags_c.bzero)
			argb_c = KELVIN_W'(1);
		else
			argb_c = kelvin - K_BLU_OFF;
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		flags_s1 <= flags_c;
		arga_s1  <= arga_c;
		argb_s1  <= argb_c;
	end

	// Datapath units.
	cttr_log2 u_log_a (.clk(clk), .n(arga_s1), .lg(lga));
	cttr_log2 u_log_b (.clk(clk), .n(argb_s1), .lg(lgb));

	cttr_lin u_lin_grn (
		.clk(clk), .lg(lga), .a_coef(GRN_A_Q16), .b_coef(GRN_B_Q16), .v(grn_lin)
	);
	cttr_lin u_lin_blu (
		.clk(clk), .lg(lgb), .a_coef(BLU_A_Q16), .b_coef(BLU_B_Q16), .v(blu_lin)
	);
	cttr_pow u_pow_red (
		.clk(clk), .lg(lga), .c_coef(RED_C_Q16), .p_coef(RED_P_Q20), .v(red_pow)
	);
	cttr_pow u_pow_grn (
		.clk(clk), .lg(lga), .c_coef(GRN_C_Q16), .p_coef(GRN_P_Q20), .v(grn_pow)
	);

	// Valid bits and flags alongside the datapath units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT_CORE; i++)
				core_vld_q[i] <= 1'b0;
		end else begin
			core_vld_q[0] <= valid_s1;
			for (int i = 1; i < LAT_CORE; i++)
				core_vld_q[i] <= core_vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		core_flg_q[0] <= flags_s1;
		for (int i = 1; i < LAT_CORE; i++)
			core_flg_q[i] <= core_flg_q[i-1];
	end

	// Channel selection by range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= core_vld_q[LAT_CORE-1];
		end
	end

	assign flags_s2 = core_flg_q[LAT_CORE-1];

	always_ff @(posedge clk) begin
		red_v_s2 <= flags_s2.hi ? red_pow : TOP_Q16;
		if (flags_s2.hi)
			grn_v_s2 <= grn_pow;
		else if (flags_s2.kzero)
			grn_v_s2 <= '0;
		else
			grn_v_s2 <= grn_lin;
		if (flags_s2.bsat)
			blu_v_s2 <= TOP_Q16;
		else if (flags_s2.bzero)
			blu_v_s2 <= '0;
		else
			blu_v_s2 <= blu_lin;
	end

	// Output levels.
	cttr_level #(.OUT_BITS(OUT_BITS)) u_lvl_red (.clk(clk), .v(red_v_s2), .lvl(red));
	cttr_level #(.OUT_BITS(OUT_BITS)) u_lvl_grn (.clk(clk), .v(grn_v_s2), .lvl(green));
	cttr_level #(.OUT_BITS(OUT_BITS)) u_lvl_blu (.clk(clk), .v(blu_v_s2), .lvl(blue));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT_LVL; i++)
				lvl_vld_q[i] <= 1'b0;
		end else begin
			lvl_vld_q[0] <= valid_s2;
			for (int i = 1; i < LAT_LVL; i++)
				lvl_vld_q[i] <= lvl_vld_q[i-1];
		end
	end

	assign done = lvl_vld_q[LAT_LVL-1];

endmodule

### tb/tb_color_temperature_to_rgb_unit.sv
// ----------------------------------------------------------------------------
// Colour temperature to RGB unit: testbench
// Drives whole-kelvin temperatures with random gaps, predicts the three
// channel levels with an independent fixed-point model and compares each
// done word against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_color_temperature_to_rgb_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import cttr_pkg::*;

	localparam int LEVEL_W = OUT_BITS_DEF;

	typedef struct {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [15:0]        kelvin;
	} rgb_word_t;

	// Fixed-point colour model and the queue of predicted words.
	class rgb_scoreboard;
		rgb_word_t pending_rgb[$];
		int        mismatches;
		longint    root_tab[1:20];

		function new();
			longint unsigned r;
			r = sqrt_floor(64'd1 << 61);
			for (int i = 1; i <= 20; i++) begin
				root_tab[i] = r;
				r = sqrt_floor(r << 30);
			end
			mismatches = 0;
		endfunction

		function longint unsigned sqrt_floor(longint unsigned x);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// Log2 in Q20 by repeated squaring of the normalised mantissa.
		function longint lg_q20(int unsigned n);
			int unsigned e;
			longint unsigned m;
			longint fr;
			e = 0;
			fr = 0;
			while (e < 31 && (n >> (e + 1)) != 0) e++;
			m = longint'(n) << (30 - e);
			for (int i = 1; i <= 20; i++) begin
				m = (m * m) >> 30;
				if (m >= (64'd1 << 31)) begin
					fr |= 64'd1 << (20 - i);
					m = m >> 1;
				end
			end
			return (longint'(e) << 20) + fr;
		endfunction

		// Signed product, rounded half away from zero after the shift.
		function longint prod_round(longint a, longint b, int sh);
			bit neg;
			longint unsigned p;
			neg = (a < 0) != (b < 0);
			p = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'd1 << (sh - 1))) >> sh;
			return neg ? -longint'(p) : longint'(p);
		endfunction

		// c * 2^(-p*lg), all in Q16 / Q20.
		function longint decay(longint c, longint p, longint lg);
			longint unsigned m, n, f, r;
			int sh;
			m = prod_round(p, lg, 20);
			n = (m + (64'd1 << 20) - 1) >> 20;
			if (n > 33) n = 33;
			f = ((n << 20) - m) & 64'hFFFFF;
			r = 64'd1 << 30;
			for (int i = 1; i <= 20; i++)
				if ((f >> (20 - i)) & 1)
					r = (r * root_tab[i] + (64'd1 << 29)) >> 30;
			sh = 30 + int'(n);
			return (c * r + (64'd1 << (sh - 1))) >> sh;
		endfunction

		function logic [LEVEL_W-1:0] level(longint v);
			longint unsigned full;
			full = (64'd1 << LEVEL_W) - 1;
			if (v <= 0) return '0;
			if (v >= longint'(TOP_Q16)) return '1;
			return LEVEL_W'((v * full + (64'd255 << 15)) / (64'd255 << 16));
		endfunction

		function void note_kelvin(logic [15:0] k);
			longint l100, r, g, b, ln, lg;
			rgb_word_t w;
			l100 = lg_q20(100);
			if (k <= 6600) begin
				r = TOP_Q16;
				if (k == 0) begin
					g = 0;
				end else begin
					ln = prod_round(lg_q20(k) - l100, longint'(LN2_Q30), 30);
					g = prod_round(longint'(GRN_A_Q16), ln, 20) - longint'(GRN_B_Q16);
				end
			end else begin
				lg = lg_q20(k - 6000) - l100;
				r = decay(longint'(RED_C_Q16), longint'(RED_P_Q20), lg);
				g = decay(longint'(GRN_C_Q16), longint'(GRN_P_Q20), lg);
			end
			if (k >= 6600) begin
				b = TOP_Q16;
			end else if (k <= 1900) begin
				b = 0;
			end else begin
				ln = prod_round(lg_q20(k - 1000) - l100, longint'(LN2_Q30), 30);
				b = prod_round(longint'(BLU_A_Q16), ln, 20) - longint'(BLU_B_Q16);
			end
			w.red = level(r);
			w.green = level(g);
			w.blue = level(b);
			w.kelvin = k;
			pending_rgb.push_back(w);
		endfunction

		function void check_word(logic [LEVEL_W-1:0] r, logic [LEVEL_W-1:0] g,
				logic [LEVEL_W-1:0] b);
			rgb_word_t w;
			if (pending_rgb.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word r=%0d g=%0d b=%0d", r, g, b);
				return;
			end
			w = pending_rgb.pop_front();
			if (r !== w.red || g !== w.green || b !== w.blue) begin
				mismatches++;
				if (mismatches <= 10)
					$display("K=%0d expected %0d/%0d/%0d got %0d/%0d/%0d", w.kelvin,
						w.red, w.green, w.blue, r, g, b);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [15:0] kelvin = '0;
	logic busy, done;
	logic [LEVEL_W-1:0] red, green, blue;
	rgb_scoreboard sb = new();

	always #5 clk = ~clk;

	color_temperature_to_rgb_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kelvin(kelvin),
		.done(done), .red(red), .green(green), .blue(blue)
	);

	// Note accepted words and check results, sampled at the edge.
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_kelvin(kelvin);
		if (arst_n && done) sb.check_word(red, green, blue);
	end

	// Offer one temperature, with a random gap first when allowed, and hold it until taken.
	task automatic send_kelvin(logic [15:0] k, bit allow_gap);
		int gap;
		gap = 0;
		if (allow_gap && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kelvin <= k;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_kelvin();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(1890, 1910));
			2: return 16'($urandom_range(6590, 6610));
			3: return 16'($urandom_range(0, 200));
			4: return 16'($urandom_range(6601, 20000));
			default: return 16'($urandom_range(1000, 12000));
		endcase
	endfunction

	initial begin
		logic [15:0] directed[$];
		bit gaps;
		directed = '{16'd0, 16'd1, 16'd2, 16'd99, 16'd100, 16'd1000, 16'd1899, 16'd1900,
			16'd1901, 16'd2000, 16'd4000, 16'd6599, 16'd6600, 16'd6601, 16'd6700,
			16'd10000, 16'd40000, 16'd65534, 16'd65535, 16'hAAAA, 16'h5555};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_kelvin(directed[i], 1'b0);
		gaps = 1'b1;
		for (int i = 0; i < 1450; i++) begin
			// Stretches without any gaps now and then.
			if (i % 200 == 0) gaps = $urandom_range(0, 2) != 0;
			send_kelvin(pick_kelvin(), gaps);
		end
		start <= 1'b0;
		while (sb.pending_rgb.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("tb_color_temperature_to_rgb_unit passed");
		end else begin
			$display("tb_color_temperature_to_rgb_unit failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("tb_color_temperature_to_rgb_unit failed");
		$finish;
	end
endmodule
